### rtl/bbiu_pkg.sv
// ----------------------------------------------------------------------------
// bbiu_pkg
// Shared types and constants of the byte/bit file-instruction unit:
// instruction codes, special register addresses and stage structs.
// ----------------------------------------------------------------------------
package bbiu_pkg;

   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int PC_BITS   = 21;
   localparam int NEXT_PC_W = 21;

   localparam logic [MEM_AW-1:0] ADDR_WREG   = MEM_AW'(12'hFE8);
   localparam logic [MEM_AW-1:0] ADDR_STATUS = MEM_AW'(12'hFD8);
   localparam logic [MEM_AW-1:0] ADDR_BSR    = MEM_AW'(12'hFE0);

   localparam logic [2:0] PC_ADV_NONE = 3'd0;
   localparam logic [2:0] PC_ADV_NEXT = 3'd2;
   localparam logic [2:0] PC_ADV_SKIP = 3'd4;

   typedef enum logic [3:0] {
      FN_BCF    = 4'd0,
      FN_BSF    = 4'd1,
      FN_BTG    = 4'd2,
      FN_BTFSC  = 4'd3,
      FN_BTFSS  = 4'd4,
      FN_TSTFSZ = 4'd5,
      FN_SUBWF  = 4'd6,
      FN_SUBWFB = 4'd7,
      FN_SWAPF  = 4'd8,
      FN_XORWF  = 4'd9,
      FN_POKE   = 4'd10,
      FN_PEEK   = 4'd11
   } func_type;

   // instruction held in the execute stage
   typedef struct packed {
      func_type            func;
      logic [2:0]          bit_index;
      logic [7:0]          raw_value;
      logic [MEM_AW-1:0]   rd_addr;
      logic                wr_en;
      logic [MEM_AW-1:0]   wr_addr;
   } exec_item_type;

   typedef struct packed {
      logic                en;
      logic [MEM_AW-1:0]   addr;
      logic [7:0]          data;
   } mem_wr_type;

   typedef struct packed {
      logic [7:0] res;
      logic [7:0] status;
      logic       skip;
      logic [2:0] pc_adv;
   } exec_result_type;

   function automatic logic is_special(input logic [MEM_AW-1:0] addr);
      return (addr == ADDR_WREG) || (addr == ADDR_STATUS) || (addr == ADDR_BSR);
   endfunction

endpackage

### rtl/pic18_byte_bit_instruction_unit.sv
// ----------------------------------------------------------------------------
// pic18_byte_bit_instruction_unit
// Byte/bit file-instruction unit with a 4096-byte data memory; WREG,
// STATUS and BSR are held in registers at their mapped addresses.
// ----------------------------------------------------------------------------
// After reset the unit clears all 4096 bytes of its data memory, one byte a
// cycle, and takes no instruction until that sweep is done. After that it
// takes one instruction a cycle unless held off as told below: the beat it
// is accepted on reads the data memory into a registered read port, and the
// execute stage then executes, writes back and loads the output register,
// from which the result beat is offered. An instruction that writes BSR
// holds off the following instruction until that write is done, since the
// bank of the next address comes from BSR; a result beat not taken stalls
// the unit after one more instruction.
// ----------------------------------------------------------------------------
module pic18_byte_bit_instruction_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[3:0] file_address[11:4] access_bank[12] dest_select[13]
   // bit_index[16:14] raw_address[28:17] raw_value[36:29] zero[39:37]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[7:0] next_pc[28:8] skipped[29] status_flags[34:30] zero[39:35]
   output logic [39:0] rsp_tdata
);

   bbiu_pkg::func_type              a_func;
   logic [7:0]                      a_file_addr;
   logic                            a_access;
   logic                            a_dest;
   logic [bbiu_pkg::MEM_AW-1:0]     a_raw_addr;
   logic [bbiu_pkg::MEM_AW-1:0]     a_ea;
   bbiu_pkg::exec_item_type         a_item;

   logic                            req_fire;
   logic                            mem_busy;
   logic [7:0]                      mem_rd_data;
   bbiu_pkg::mem_wr_type            mem_wr;

   logic                            e_valid_ff;
   logic                            e_valid_in;
   bbiu_pkg::exec_item_type         e_item_ff;
   logic                            e_advance;
   logic                            e_bsr_write;
   logic [7:0]                      e_operand;
   bbiu_pkg::exec_result_type       e_result;

   logic [7:0]                      wreg_ff;
   logic [7:0]                      wreg_in;
   logic [7:0]                      status_ff;
   logic [7:0]                      bsr_ff;
   logic [7:0]                      bsr_in;
   logic [bbiu_pkg::PC_BITS-1:0]    pc_ff;
   logic [bbiu_pkg::PC_BITS-1:0]    pc_in;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [39:0]                     rsp_data_ff;

   // decode and address of the incoming beat
   always_comb begin
      a_func      = bbiu_pkg::func_type'(req_tdata[3:0]);
      a_file_addr = req_tdata[11:4];
      a_access    = req_tdata[12];
      a_dest      = req_tdata[13];
      a_raw_addr  = req_tdata[28:17];

      if (a_access) begin
         a_ea = {bsr_ff[3:0], a_file_addr};
      end else if (a_file_addr[7]) begin
         a_ea = {4'hF, a_file_addr};
      end else begin
         a_ea = {4'h0, a_file_addr};
      end

      a_item.func      = a_func;
      a_item.bit_index = req_tdata[16:14];
      a_item.raw_value = req_tdata[36:29];
      a_item.rd_addr   = a_ea;
      a_item.wr_en     = 1'b0;
      a_item.wr_addr   = a_ea;

      unique case (a_func)
         bbiu_pkg::FN_BCF, bbiu_pkg::FN_BSF, bbiu_pkg::FN_BTG: begin
            a_item.wr_en = 1'b1;
         end
         bbiu_pkg::FN_SUBWF, bbiu_pkg::FN_SUBWFB,
         bbiu_pkg::FN_SWAPF, bbiu_pkg::FN_XORWF: begin
            a_item.wr_en   = 1'b1;
            a_item.wr_addr = a_dest ? a_ea : bbiu_pkg::ADDR_WREG;
         end
         bbiu_pkg::FN_POKE: begin
            a_item.wr_en   = 1'b1;
            a_item.rd_addr = a_raw_addr;
            a_item.wr_addr = a_raw_addr;
         end
         bbiu_pkg::FN_PEEK: begin
            a_item.rd_addr = a_raw_addr;
         end
         default: begin
            a_item.wr_en = 1'b0;
         end
      endcase
   end

   assign e_bsr_write = e_valid_ff && e_item_ff.wr_en &&
                        (e_item_ff.wr_addr == bbiu_pkg::ADDR_BSR);
   assign e_advance   = e_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !mem_busy && (!e_valid_ff || (e_advance && !e_bsr_write));
   assign req_fire    = req_tvalid && req_tready;

   always_comb begin
      mem_wr.en   = e_advance && e_item_ff.wr_en &&
                    !bbiu_pkg::is_special(e_item_ff.wr_addr);
      mem_wr.addr = e_item_ff.wr_addr;
      mem_wr.data = e_result.res;
   end

   bbiu_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (a_item.rd_addr),
      .wr      (mem_wr),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   always_comb begin
      if (e_item_ff.rd_addr == bbiu_pkg::ADDR_WREG) begin
         e_operand = wreg_ff;
      end else if (e_item_ff.rd_addr == bbiu_pkg::ADDR_STATUS) begin
         e_operand = status_ff;
      end else if (e_item_ff.rd_addr == bbiu_pkg::ADDR_BSR) begin
         e_operand = bsr_ff;
      end else begin
         e_operand = mem_rd_data;
      end
   end

   bbiu_exec u_exec (
      .item    (e_item_ff),
      .f_value (e_operand),
      .wreg    (wreg_ff),
      .status  (status_ff),
      .result  (e_result)
   );

   always_comb begin
      wreg_in = wreg_ff;
      bsr_in  = bsr_ff;
      if (e_item_ff.wr_en && (e_item_ff.wr_addr == bbiu_pkg::ADDR_WREG)) begin
         wreg_in = e_result.res;
      end
      if (e_item_ff.wr_en && (e_item_ff.wr_addr == bbiu_pkg::ADDR_BSR)) begin
         bsr_in = e_result.res;
      end
      pc_in = pc_ff + bbiu_pkg::PC_BITS'(e_result.pc_adv);

      e_valid_in = e_valid_ff;
      if (req_fire) begin
         e_valid_in = 1'b1;
      end else if (e_advance) begin
         e_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (e_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wreg_ff      <= 8'h00;
         status_ff    <= 8'h00;
         bsr_ff       <= 8'h00;
         pc_ff        <= '0;
      end else begin
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (e_advance) begin
            wreg_ff   <= wreg_in;
            status_ff <= e_result.status;
            bsr_ff    <= bsr_in;
            pc_ff     <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         e_item_ff <= a_item;
      end
      if (e_advance) begin
         rsp_data_ff <= {5'b0, e_result.status[4:0], e_result.skip,
                         bbiu_pkg::NEXT_PC_W'(pc_in), e_result.res};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/bbiu_dmem.sv
// ----------------------------------------------------------------------------
// bbiu_dmem
// Data memory: one write port and one registered read port, a clearing
// sweep after reset, and write-to-read forwarding for same-edge collisions.
// ----------------------------------------------------------------------------
module bbiu_dmem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [bbiu_pkg::MEM_AW-1:0]   rd_addr,
   input  bbiu_pkg::mem_wr_type          wr,
   output logic [7:0]                    rd_data,
   output logic                          busy
);

   logic [7:0]                  data_mem_ff [bbiu_pkg::MEM_BYTES];
   logic [7:0]                  mem_q_ff;
   logic                        fwd_hit_ff;
   logic [7:0]                  fwd_data_ff;
   logic                        clr_busy_ff;
   logic                        clr_busy_in;
   logic [bbiu_pkg::MEM_AW-1:0] clr_addr_ff;
   logic [bbiu_pkg::MEM_AW-1:0] clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         data_mem_ff[clr_addr_ff] <= 8'h00;
      end else if (wr.en) begin
         data_mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= data_mem_ff[rd_addr];
         fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : mem_q_ff;
   assign busy    = clr_busy_ff;

endmodule

### rtl/bbiu_exec.sv
// ----------------------------------------------------------------------------
// bbiu_exec
// Execute logic: bit operations, skip tests, subtract with borrow,
// nibble swap, exclusive or and raw poke and peek, with the STATUS flag update.
// ----------------------------------------------------------------------------
module bbiu_exec (
   input  bbiu_pkg::exec_item_type   item,
   input  logic [7:0]                f_value,
   input  logic [7:0]                wreg,
   input  logic [7:0]                status,
   output bbiu_pkg::exec_result_type result
);

   logic [7:0] bit_mask;
   logic [7:0] not_w;
   logic       cin;
   logic [8:0] sum9;
   logic [4:0] sum_lo;
   logic [7:0] sub_res;
   logic [4:0] sub_flags;
   logic [7:0] xor_res;
   logic [7:0] status_flagged;

   always_comb begin
      bit_mask  = 8'd1 << item.bit_index;
      not_w     = ~wreg;
      cin       = (item.func == bbiu_pkg::FN_SUBWFB) ? status[0] : 1'b1;
      sum9      = {1'b0, f_value} + {1'b0, not_w} + 9'(cin);
      sum_lo    = {1'b0, f_value[3:0]} + {1'b0, not_w[3:0]} + 5'(cin);
      sub_res   = sum9[7:0];
      sub_flags = {sub_res[7],
                   (f_value[7] == not_w[7]) && (f_value[7] != sub_res[7]),
                   sub_res == 8'h00,
                   sum_lo[4],
                   sum9[8]};
      xor_res   = f_value ^ wreg;

      status_flagged = status;
      result.res     = 8'h00;
      result.skip    = 1'b0;
      result.pc_adv  = bbiu_pkg::PC_ADV_NEXT;

      unique case (item.func)
         bbiu_pkg::FN_BCF:    result.res = f_value & ~bit_mask;
         bbiu_pkg::FN_BSF:    result.res = f_value | bit_mask;
         bbiu_pkg::FN_BTG:    result.res = f_value ^ bit_mask;
         bbiu_pkg::FN_BTFSC: begin
            result.res  = f_value;
            result.skip = (f_value & bit_mask) == 8'h00;
         end
         bbiu_pkg::FN_BTFSS: begin
            result.res  = f_value;
            result.skip = (f_value & bit_mask) != 8'h00;
         end
         bbiu_pkg::FN_TSTFSZ: begin
            result.res  = f_value;
            result.skip = f_value == 8'h00;
         end
         bbiu_pkg::FN_SUBWF, bbiu_pkg::FN_SUBWFB: begin
            result.res     = sub_res;
            status_flagged = {status[7:5], sub_flags};
         end
         bbiu_pkg::FN_SWAPF:  result.res = {f_value[3:0], f_value[7:4]};
         bbiu_pkg::FN_XORWF: begin
            result.res     = xor_res;
            status_flagged = {status[7:5], xor_res[7], status[3],
                              xor_res == 8'h00, status[1:0]};
         end
         bbiu_pkg::FN_POKE: begin
            result.res    = item.raw_value;
            result.pc_adv = bbiu_pkg::PC_ADV_NONE;
         end
         bbiu_pkg::FN_PEEK: begin
            result.res    = f_value;
            result.pc_adv = bbiu_pkg::PC_ADV_NONE;
         end
         default: begin
            result.res    = 8'h00;
            result.pc_adv = bbiu_pkg::PC_ADV_NONE;
         end
      endcase

      if (result.skip) begin
         result.pc_adv = bbiu_pkg::PC_ADV_SKIP;
      end

      // a stored byte aimed at STATUS replaces the flag update
      if (item.wr_en && (item.wr_addr == bbiu_pkg::ADDR_STATUS)) begin
         result.status = result.res;
      end else begin
         result.status = status_flagged;
      end
   end

endmodule
